>>> src/strm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strm_pkg
// Types and constants shared by the striped transfer rate meter.
// ----------------------------------------------------------------------------
package strm_pkg;

    localparam int MAX_STRIPES = 16;
    localparam int STRIPE_W    = 4;
    localparam int TIME_W      = 42;
    localparam int BYTES_W     = 48;
    localparam int COUNT_W     = 52;
    localparam int RATE_W      = 56;
    localparam int DVD_W       = 58;
    localparam int ACC_W       = 61;
    localparam int MIN_GAP_MS  = 100;

    // Opcodes
    localparam logic [1:0] OP_BEGIN    = 2'd0;
    localparam logic [1:0] OP_MARKER   = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_STRIPE_EN = 1'b0;
    localparam logic CFG_TOTAL_EN  = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] seconds;
        logic [9:0]  fraction_ms;
        logic [3:0]  stripe_index;
        logic [4:0]  stripe_count;
        logic [47:0] bytes_done;
    } item_t;

    typedef struct packed {
        logic        report_kind;
        logic [3:0]  report_stripe;
        logic [51:0] byte_count;
        logic [55:0] instant_rate;
        logic [55:0] average_rate;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0]  prev_time;
        logic [TIME_W-1:0]  cur_time;
        logic [BYTES_W-1:0] prev_count;
        logic [BYTES_W-1:0] cur_count;
    } entry_t;

endpackage
`default_nettype wire

>>> src/striped_transfer_rate_meter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// striped_transfer_rate_meter
// Per-stripe and total throughput of a striped transfer, one shared
// bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | signals                       | handshake
//  ---------+-------------------------------+-------------------------------
//  input    | start, busy, item             | taken when start & !busy
//  result   | result_valid, result          | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_data   | write when cfg_we high
//
// Begin, complete and unused-opcode items finish in the idle state; a dropped or
// out-of-range marker passes through the table read and the check. Each rate is
// one division with a set-up step before it and a step to take the quotient, so
// a stripe report takes two divisions and a total two more per stripe in use, all
// on the single restoring divider.
// Reset clears control state and table valid bits; results cannot be held off.
// ----------------------------------------------------------------------------
module striped_transfer_rate_meter
    import strm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire item_t   item,
    output logic         result_valid,
    output result_t      result,
    input  wire logic    cfg_we,
    input  wire logic    cfg_index,
    input  wire logic    cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOOK   = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_DIVSET = 4'd3;
    localparam logic [3:0] S_DIVRUN = 4'd4;
    localparam logic [3:0] S_DISP   = 4'd5;
    localparam logic [3:0] S_TRD    = 4'd6;
    localparam logic [3:0] S_TDATA  = 4'd7;
    localparam logic [3:0] S_SENDT  = 4'd8;

    localparam logic [1:0] PH_S_INST = 2'd0;
    localparam logic [1:0] PH_S_AVG  = 2'd1;
    localparam logic [1:0] PH_T_INST = 2'd2;
    localparam logic [1:0] PH_T_AVG  = 2'd3;

    localparam logic [5:0] DIV_LAST = 6'(DVD_W - 1);
    localparam logic [RATE_W-1:0] RATE_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Control state
    logic [3:0]             state_reg, state_next;
    logic [1:0]             phase_reg, phase_next;
    logic                   stripe_en_reg, total_en_reg;
    logic                   ready_reg, ready_next;
    logic                   seen_reg, seen_next;
    logic [4:0]             stripes_reg, stripes_next;
    logic [MAX_STRIPES-1:0] valid_reg, valid_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [4:0]             idx_reg, idx_next;
    logic                   strobe_next;

    // Datapath
    logic [TIME_W-1:0]  start_ms_reg, start_ms_next;
    logic [TIME_W-1:0]  t_reg, t_next;
    logic [3:0]         s_reg, s_next;
    logic [BYTES_W-1:0] nb_reg, nb_next;
    logic [BYTES_W-1:0] num_reg, num_next;
    logic [TIME_W-1:0]  end_reg, end_next;
    logic [TIME_W-1:0]  beg_reg, beg_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [TIME_W-1:0]  rem_reg, rem_next;
    logic [TIME_W-1:0]  dsr_reg, dsr_next;
    logic [RATE_W-1:0]  inst_reg, inst_next;
    logic [BYTES_W-1:0] tcb_reg, tcb_next;
    logic [TIME_W-1:0]  tct_reg, tct_next;
    logic [ACC_W-1:0]   acc_inst_reg, acc_inst_next;
    logic [ACC_W-1:0]   acc_avg_reg, acc_avg_next;
    logic [COUNT_W-1:0] acc_sum_reg, acc_sum_next;
    result_t            out_reg, out_next;

    // Table memory
    entry_t             mem [MAX_STRIPES];
    entry_t             rd_reg;
    logic               rd_vld_reg;
    logic [3:0]         rd_addr;
    logic               mem_we;
    logic [3:0]         mem_addr;
    entry_t             mem_wdata;

    // Helpers
    entry_t             ent;
    logic [TIME_W-1:0]  ct_adj;
    logic               drop;
    logic [TIME_W:0]    sh;
    logic               qbit;
    logic [TIME_W-1:0]  elapsed;
    logic [RATE_W-1:0]  q_sat;
    logic [DVD_W-1:0]   scaled;

    assign busy         = (state_reg != S_IDLE);
    assign result       = out_reg;
    assign ent          = rd_vld_reg ? rd_reg : '0;
    assign elapsed      = end_reg - beg_reg;
    assign q_sat        = (dvd_reg > DVD_W'(RATE_MAX)) ? RATE_MAX : dvd_reg[RATE_W-1:0];
    assign scaled       = {num_reg, 10'b0} - {6'b0, num_reg, 4'b0} - {7'b0, num_reg, 3'b0};
    assign sh           = {rem_reg, dvd_reg[DVD_W-1]};
    assign qbit         = (sh >= {1'b0, dsr_reg});
    assign rd_addr      = (state_reg == S_LOOK) ? s_reg : idx_reg[3:0];

    // Write and read the table, read registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_reg     <= mem[rd_addr];
        rd_vld_reg <= valid_reg[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stripe_en_reg <= 1'b1;
            total_en_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STRIPE_EN: stripe_en_reg <= cfg_data;
                CFG_TOTAL_EN:  total_en_reg  <= cfg_data;
                default:       stripe_en_reg <= stripe_en_reg;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        ready_next    = ready_reg;
        seen_next     = seen_reg;
        stripes_next  = stripes_reg;
        valid_next    = valid_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        strobe_next   = 1'b0;
        start_ms_next = start_ms_reg;
        t_next        = t_reg;
        s_next        = s_reg;
        nb_next       = nb_reg;
        num_next      = num_reg;
        end_next      = end_reg;
        beg_next      = beg_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dsr_next      = dsr_reg;
        inst_next     = inst_reg;
        tcb_next      = tcb_reg;
        tct_next      = tct_reg;
        acc_inst_next = acc_inst_reg;
        acc_avg_next  = acc_avg_reg;
        acc_sum_next  = acc_sum_reg;
        out_next      = out_reg;
        mem_we        = 1'b0;
        mem_addr      = s_reg;
        mem_wdata     = ent;
        ct_adj        = ent.cur_time;
        drop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    t_next  = TIME_W'(item.seconds) * TIME_W'(1000)
                            + TIME_W'(item.fraction_ms);
                    s_next  = item.stripe_index;
                    nb_next = item.bytes_done;
                    case (item.opcode)
                        OP_BEGIN:    start_ms_next = t_next;
                        OP_COMPLETE: ready_next = 1'b0;
                        OP_MARKER:
                        begin
                            // Set up a cleared table on the first marker
                            if (!ready_reg)
                            begin
                                ready_next   = 1'b1;
                                seen_next    = 1'b0;
                                valid_next   = '0;
                                stripes_next = (item.stripe_count > 5'(MAX_STRIPES))
                                             ? 5'(MAX_STRIPES) : item.stripe_count;
                            end
                            state_next = S_LOOK;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            S_LOOK: state_next = S_CHECK;

            S_CHECK:
            begin
                if ({1'b0, s_reg} >= stripes_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    // Fix the stripe start time
                    if (ent.cur_time < TIME_W'(MIN_GAP_MS))
                    begin
                        if (nb_reg == '0)
                        begin
                            ct_adj = t_reg;
                            if (!seen_reg)
                            begin
                                start_ms_next = t_reg;
                                seen_next     = 1'b1;
                            end
                        end
                        else
                        begin
                            ct_adj = start_ms_reg;
                        end
                    end
                    drop = ({1'b0, t_reg} < ({1'b0, ct_adj} + (TIME_W+1)'(MIN_GAP_MS)))
                         || (nb_reg < ent.cur_count);
                    mem_we            = 1'b1;
                    valid_next[s_reg] = 1'b1;
                    if (drop)
                    begin
                        mem_wdata.cur_time = ct_adj;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        mem_wdata.prev_time  = ct_adj;
                        mem_wdata.cur_time   = t_reg;
                        mem_wdata.prev_count = ent.cur_count;
                        mem_wdata.cur_count  = nb_reg;
                        acc_inst_next = '0;
                        acc_avg_next  = '0;
                        acc_sum_next  = '0;
                        idx_next      = '0;
                        if (stripe_en_reg)
                        begin
                            num_next   = nb_reg - ent.cur_count;
                            end_next   = t_reg;
                            beg_next   = ct_adj;
                            phase_next = PH_S_INST;
                            state_next = S_DIVSET;
                        end
                        else if (total_en_reg)
                        begin
                            state_next = S_TRD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            S_DIVSET:
            begin
                // Short or negative elapsed time gives a rate of zero
                if ((end_reg < beg_reg) || (elapsed < TIME_W'(MIN_GAP_MS)))
                begin
                    dvd_next   = '0;
                    state_next = S_DISP;
                end
                else
                begin
                    dvd_next   = scaled;
                    rem_next   = '0;
                    dsr_next   = elapsed;
                    cnt_next   = '0;
                    state_next = S_DIVRUN;
                end
            end

            S_DIVRUN:
            begin
                // One quotient bit a cycle
                rem_next = qbit ? TIME_W'(sh - {1'b0, dsr_reg}) : sh[TIME_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], qbit};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                case (phase_reg)
                    PH_S_INST:
                    begin
                        inst_next  = q_sat;
                        num_next   = nb_reg;
                        end_next   = t_reg;
                        beg_next   = start_ms_reg;
                        phase_next = PH_S_AVG;
                        state_next = S_DIVSET;
                    end
                    PH_S_AVG:
                    begin
                        out_next.report_kind   = 1'b0;
                        out_next.report_stripe = s_reg;
                        out_next.byte_count    = COUNT_W'(nb_reg);
                        out_next.instant_rate  = inst_reg;
                        out_next.average_rate  = q_sat;
                        out_next.last          = !total_en_reg;
                        strobe_next            = 1'b1;
                        state_next             = total_en_reg ? S_TRD : S_IDLE;
                    end
                    PH_T_INST:
                    begin
                        acc_inst_next = acc_inst_reg + ACC_W'(q_sat);
                        num_next      = tcb_reg;
                        end_next      = tct_reg;
                        beg_next      = start_ms_reg;
                        phase_next    = PH_T_AVG;
                        state_next    = S_DIVSET;
                    end
                    default:
                    begin
                        acc_avg_next = acc_avg_reg + ACC_W'(q_sat);
                        idx_next     = idx_reg + 5'd1;
                        state_next   = ((idx_reg + 5'd1) == stripes_reg) ? S_SENDT : S_TRD;
                    end
                endcase
            end

            S_TRD: state_next = S_TDATA;

            S_TDATA:
            begin
                // Accumulate bytes and start this stripe's instant rate
                acc_sum_next = acc_sum_reg + COUNT_W'(ent.cur_count);
                tcb_next     = ent.cur_count;
                tct_next     = ent.cur_time;
                num_next     = (ent.cur_count >= ent.prev_count)
                             ? (ent.cur_count - ent.prev_count) : '0;
                end_next     = ent.cur_time;
                beg_next     = ent.prev_time;
                phase_next   = PH_T_INST;
                state_next   = S_DIVSET;
            end

            S_SENDT:
            begin
                out_next.report_kind   = 1'b1;
                out_next.report_stripe = '0;
                out_next.byte_count    = acc_sum_reg;
                out_next.instant_rate  = (acc_inst_reg > ACC_W'(RATE_MAX))
                                       ? RATE_MAX : acc_inst_reg[RATE_W-1:0];
                out_next.average_rate  = (acc_avg_reg > ACC_W'(RATE_MAX))
                                       ? RATE_MAX : acc_avg_reg[RATE_W-1:0];
                out_next.last          = 1'b1;
                strobe_next            = 1'b1;
                state_next             = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_S_INST;
            ready_reg    <= 1'b0;
            seen_reg     <= 1'b0;
            stripes_reg  <= '0;
            valid_reg    <= '0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            result_valid <= 1'b0;
            start_ms_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            ready_reg    <= ready_next;
            seen_reg     <= seen_next;
            stripes_reg  <= stripes_next;
            valid_reg    <= valid_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            result_valid <= strobe_next;
            start_ms_reg <= start_ms_next;
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        s_reg        <= s_next;
        nb_reg       <= nb_next;
        num_reg      <= num_next;
        end_reg      <= end_next;
        beg_reg      <= beg_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        inst_reg     <= inst_next;
        tcb_reg      <= tcb_next;
        tct_reg      <= tct_next;
        acc_inst_reg <= acc_inst_next;
        acc_avg_reg  <= acc_avg_next;
        acc_sum_reg  <= acc_sum_next;
        out_reg      <= out_next;
    end

`ifndef SYNTHESIS
    // A final result is never followed straight away by another
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("result strobe after final transaction");

    // A report that is not the last one must be a per-stripe report
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> !result.report_kind)
        else $error("non-final total report");

    // Totals carry stripe zero and close the transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.report_kind |-> result.report_stripe == '0 && result.last)
        else $error("malformed total report");

    // No result appears out of an idle sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_valid)
        else $error("result strobe from idle");
`endif

endmodule
`default_nettype wire

>>> bench/striped_transfer_rate_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// striped_transfer_rate_meter_tb
// Drives begin, marker and complete transactions into the rate meter and
// checks every per-stripe and total report against a local model of the
// stripe table, under several report-enable settings and random idling.
// ----------------------------------------------------------------------------
module striped_transfer_rate_meter_tb;
    import strm_pkg::*;

    localparam logic [63:0] RATE_SAT  = (64'd1 << 56) - 64'd1;
    localparam logic [63:0] COUNT_SAT = (64'd1 << 52) - 64'd1;
    localparam logic [63:0] TIME_TOP  = 64'd4294967295000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    result_valid;
    result_t result;
    logic    cfg_we;
    logic    cfg_index;
    logic    cfg_data;

    striped_transfer_rate_meter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // model state of the meter
    logic        stripe_rep_en;
    logic        total_rep_en;
    logic        tbl_ready;
    int unsigned n_stripes;
    logic [63:0] xfer_start_ms;
    logic        start_seen;
    logic [63:0] prev_ms  [MAX_STRIPES];
    logic [63:0] cur_ms   [MAX_STRIPES];
    logic [63:0] prev_cnt [MAX_STRIPES];
    logic [63:0] cur_cnt  [MAX_STRIPES];

    result_t     expected_reports[$];
    int          n_errors;
    bit          gaps_on;
    logic [63:0] now_ms;

    // free-running clock, 10 ns period
    always #5 clk = ~clk;

    // bytes per second over an interval, zero when under the minimum gap
    function automatic logic [63:0] rate_bps(logic [63:0] nbytes, logic [63:0] t_end,
                                             logic [63:0] t_begin);
        logic [63:0] q;
        if (t_end < t_begin || t_end - t_begin < MIN_GAP_MS)
            return 64'd0;
        q = (nbytes * 64'd1000) / (t_end - t_begin);
        return (q > RATE_SAT) ? RATE_SAT : q;
    endfunction

    function automatic result_t make_report(logic kind, logic [3:0] s, logic [63:0] cnt,
                                            logic [63:0] inst, logic [63:0] avg);
        result_t r;
        r.report_kind   = kind;
        r.report_stripe = s;
        r.byte_count    = (cnt > COUNT_SAT) ? COUNT_SAT[51:0] : cnt[51:0];
        r.instant_rate  = (inst > RATE_SAT) ? RATE_SAT[55:0] : inst[55:0];
        r.average_rate  = (avg > RATE_SAT) ? RATE_SAT[55:0] : avg[55:0];
        r.last          = 1'b0;
        return r;
    endfunction

    // advance the model by one accepted transaction and queue its reports
    task automatic predict_reports(item_t it);
        logic [63:0] t;
        logic [63:0] nb;
        logic [63:0] sum;
        logic [63:0] inst;
        logic [63:0] avg;
        logic [63:0] d;
        int unsigned s;
        int          n;
        result_t     r;
        t  = 64'(it.seconds) * 64'd1000 + 64'(it.fraction_ms);
        nb = 64'(it.bytes_done);
        s  = it.stripe_index;
        n  = 0;
        if (it.opcode == OP_BEGIN) begin
            xfer_start_ms = t;
            return;
        end
        if (it.opcode == OP_COMPLETE) begin
            tbl_ready = 1'b0;
            return;
        end
        if (it.opcode != OP_MARKER)
            return;
        if (!tbl_ready) begin
            tbl_ready  = 1'b1;
            start_seen = 1'b0;
            n_stripes  = (it.stripe_count > MAX_STRIPES) ? MAX_STRIPES : it.stripe_count;
            for (int i = 0; i < MAX_STRIPES; i++) begin
                prev_ms[i] = 0; cur_ms[i] = 0; prev_cnt[i] = 0; cur_cnt[i] = 0;
            end
        end
        if (s >= n_stripes)
            return;
        // stripe start handling
        if (cur_ms[s] < MIN_GAP_MS) begin
            if (nb == 0) begin
                cur_ms[s] = t;
                if (!start_seen) begin
                    xfer_start_ms = t;
                    start_seen    = 1'b1;
                end
            end
            else begin
                cur_ms[s] = xfer_start_ms;
            end
        end
        // drop early or shrinking markers
        if (t < cur_ms[s] + MIN_GAP_MS || nb < cur_cnt[s])
            return;
        prev_ms[s]  = cur_ms[s];
        cur_ms[s]   = t;
        prev_cnt[s] = cur_cnt[s];
        cur_cnt[s]  = nb;
        if (stripe_rep_en) begin
            r = make_report(1'b0, s[3:0], nb, rate_bps(nb - prev_cnt[s], t, prev_ms[s]),
                            rate_bps(nb, t, xfer_start_ms));
            expected_reports.push_back(r);
            n++;
        end
        if (total_rep_en) begin
            sum = 0; inst = 0; avg = 0;
            for (int i = 0; i < n_stripes; i++) begin
                d = (cur_cnt[i] >= prev_cnt[i]) ? cur_cnt[i] - prev_cnt[i] : 64'd0;
                sum  += cur_cnt[i];
                inst += rate_bps(d, cur_ms[i], prev_ms[i]);
                avg  += rate_bps(cur_cnt[i], cur_ms[i], xfer_start_ms);
            end
            expected_reports.push_back(make_report(1'b1, 4'd0, sum, inst, avg));
            n++;
        end
        if (n > 0)
            expected_reports[$].last = 1'b1;
    endtask

    task automatic flag_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    // compare each report transaction against the oldest expectation
    always @(posedge clk) begin
        result_t want;
        if (rst_n && result_valid) begin
            if (expected_reports.size() == 0) begin
                flag_mismatch("report with none expected");
            end
            else begin
                want = expected_reports.pop_front();
                if (result.report_kind !== want.report_kind)
                    flag_mismatch($sformatf("report_kind %0h want %0h",
                                            result.report_kind, want.report_kind));
                if (result.report_stripe !== want.report_stripe)
                    flag_mismatch($sformatf("report_stripe %0h want %0h",
                                            result.report_stripe, want.report_stripe));
                if (result.byte_count !== want.byte_count)
                    flag_mismatch($sformatf("byte_count %0h want %0h",
                                            result.byte_count, want.byte_count));
                if (result.instant_rate !== want.instant_rate)
                    flag_mismatch($sformatf("instant_rate %0h want %0h",
                                            result.instant_rate, want.instant_rate));
                if (result.average_rate !== want.average_rate)
                    flag_mismatch($sformatf("average_rate %0h want %0h",
                                            result.average_rate, want.average_rate));
                if (result.last !== want.last)
                    flag_mismatch($sformatf("last %0h want %0h", result.last, want.last));
            end
        end
    end

    function automatic item_t mk_item(logic [1:0] op, logic [63:0] ms, int s, int cnt,
                                      logic [47:0] nb);
        item_t it;
        it.opcode       = op;
        it.seconds      = 32'(ms / 1000);
        it.fraction_ms  = 10'(ms % 1000);
        it.stripe_index = 4'(s);
        it.stripe_count = 5'(cnt);
        it.bytes_done   = nb;
        return it;
    endfunction

    // offer one transaction, hold it until taken, then predict
    task automatic send_item(item_t it);
        if (gaps_on && $urandom_range(0, 99) < 13) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item  <= it;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        predict_reports(it);
    endtask

    // lower start and wait until the meter has gone quiet
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (expected_reports.size() != 0);
        while (busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_enables(logic stripe_en, logic total_en);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STRIPE_EN;
        cfg_data  <= stripe_en;
        @(posedge clk);
        cfg_index <= CFG_TOTAL_EN;
        cfg_data  <= total_en;
        @(posedge clk);
        cfg_we    <= 1'b0;
        stripe_rep_en = stripe_en;
        total_rep_en  = total_en;
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // one transfer: begin, a run of markers with random content, complete
    task automatic run_transfer(int n_markers);
        logic [63:0] moved [MAX_STRIPES];
        logic [47:0] nb;
        int          cnt;
        int          s;
        int          pick;
        item_t       it;
        pick = $urandom_range(0, 99);
        cnt  = (pick < 70) ? $urandom_range(1, 4) : (pick < 85) ? $urandom_range(5, 16) :
               (pick < 92) ? MAX_STRIPES : (pick < 96) ? 0 : $urandom_range(17, 31);
        for (int i = 0; i < MAX_STRIPES; i++) moved[i] = 0;
        if ($urandom_range(0, 9) == 0)
            now_ms = {$urandom, $urandom} % (TIME_TOP - 64'd100000000);
        if (now_ms > TIME_TOP - 64'd100000000)
            now_ms = $urandom_range(0, 5000);
        if ($urandom_range(0, 9) < 8)
            send_item(mk_item(OP_BEGIN, now_ms, $urandom_range(0, 15),
                              $urandom_range(0, 31), rand48()));
        for (int k = 0; k < n_markers; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                // noise: unused opcode or a stray begin
                it = mk_item($urandom_range(0, 1) ? 2'd3 : OP_BEGIN, now_ms,
                             $urandom_range(0, 15), $urandom_range(0, 31), rand48());
                it.fraction_ms = 10'($urandom);
                send_item(it);
                continue;
            end
            s = (pick < 12 || cnt == 0) ? $urandom_range(0, 15)
                                         : $urandom_range(0, (cnt > 16 ? 16 : cnt) - 1);
            now_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99)
                                                   : $urandom_range(100, 4000);
            pick = $urandom_range(0, 99);
            if (moved[s] == 0 && pick < 40)
                nb = 0;
            else if (pick < 48 && moved[s] != 0)
                nb = 48'(moved[s] - $urandom_range(1, 1000));
            else if (pick < 55)
                nb = rand48();
            else
                nb = 48'(moved[s] + $urandom_range(0, 50000000));
            if (nb >= moved[s]) moved[s] = nb;
            send_item(mk_item(OP_MARKER, now_ms, s, cnt, nb));
        end
        if ($urandom_range(0, 9) < 9)
            send_item(mk_item(OP_COMPLETE, now_ms, $urandom_range(0, 15),
                              $urandom_range(0, 31), rand48()));
    endtask

    task automatic test_directed();
        item_t it;
        send_item(mk_item(OP_BEGIN, 64'd1000, 0, 0, 0));
        // two stripes, both started with zero-byte markers
        send_item(mk_item(OP_MARKER, 64'd1500, 0, 2, 0));
        send_item(mk_item(OP_MARKER, 64'd1550, 1, 2, 0));
        send_item(mk_item(OP_MARKER, 64'd1700, 0, 2, 48'd1000));
        send_item(mk_item(OP_MARKER, 64'd1800, 1, 2, 48'hFFFF_FFFF_FFFF));
        // too soon, then fewer bytes: both dropped
        send_item(mk_item(OP_MARKER, 64'd1750, 0, 2, 48'd2000));
        send_item(mk_item(OP_MARKER, 64'd2500, 0, 2, 48'd10));
        // stripe out of range and unused opcode
        send_item(mk_item(OP_MARKER, 64'd2600, 5, 2, 48'd10));
        send_item(mk_item(2'd3, 64'd2600, 0, 2, 48'd10));
        send_item(mk_item(OP_MARKER, 64'd2700, 0, 2, 48'hFFFF_FFFF_FFFF));
        send_item(mk_item(OP_COMPLETE, 64'd2700, 0, 0, 0));
        // zero stripe count ignores everything until complete
        send_item(mk_item(OP_MARKER, 64'd3000, 0, 0, 0));
        send_item(mk_item(OP_MARKER, 64'd4000, 0, 5, 48'd100));
        send_item(mk_item(OP_COMPLETE, 64'd4000, 0, 0, 0));
        // begin far in the future: markers before it are dropped
        send_item(mk_item(OP_BEGIN, 64'd900000, 0, 0, 0));
        send_item(mk_item(OP_MARKER, 64'd5000, 15, 31, 48'd777));
        send_item(mk_item(OP_MARKER, 64'd5050, 15, 31, 48'd800));
        send_item(mk_item(OP_COMPLETE, 64'd5050, 0, 0, 0));
        // largest timestamp, fraction field above 999
        send_item(mk_item(OP_BEGIN, TIME_TOP - 64'd5000, 0, 0, 0));
        send_item(mk_item(OP_MARKER, TIME_TOP - 64'd5000, 3, 16, 0));
        it = mk_item(OP_MARKER, TIME_TOP, 3, 16, 48'hFFFF_FFFF_FFFF);
        it.fraction_ms = 10'd1023;
        send_item(it);
        send_item(mk_item(OP_COMPLETE, TIME_TOP, 15, 31, 48'hFFFF_FFFF_FFFF));
        settle();
    endtask

    task automatic test_enables();
        write_enables(1'b0, 1'b1);
        run_transfer(8);
        settle();
        write_enables(1'b1, 1'b0);
        run_transfer(8);
        settle();
        write_enables(1'b0, 1'b0);
        run_transfer(6);
        settle();
        write_enables(1'b1, 1'b1);
    endtask

    task automatic test_random();
        // hold gaps off for a long stretch, then bring them back
        gaps_on = 1'b0;
        for (int k = 0; k < 5; k++) run_transfer($urandom_range(6, 14));
        gaps_on = 1'b1;
        // pause until every report has come back
        settle();
        for (int k = 0; k < 14; k++) run_transfer($urandom_range(6, 14));
        settle();
    endtask

    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = 1'b0;
        n_errors  = 0;
        gaps_on   = 1'b1;
        now_ms    = 64'd10000;
        stripe_rep_en = 1'b1;
        total_rep_en  = 1'b1;
        tbl_ready     = 1'b0;
        n_stripes     = 0;
        xfer_start_ms = 0;
        start_seen    = 1'b0;
        for (int i = 0; i < MAX_STRIPES; i++) begin
            prev_ms[i] = 0; cur_ms[i] = 0; prev_cnt[i] = 0; cur_cnt[i] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_enables();
        test_random();
        repeat (2500) @(posedge clk);
        if (n_errors == 0 && expected_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
